// ===== src/string_to_int64_parser_macros.svh =====
// Assertion helpers for the string to int64 parser.
`ifndef STRING_TO_INT64_PARSER_MACROS_SVH
`define STRING_TO_INT64_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled at the clock, off during reset.
`define S2I_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("s2i check failed");

// Next-cycle implication.
`define S2I_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("s2i check failed");

`else

`define S2I_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define S2I_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/s2i_pkg.sv =====
package s2i_pkg;

  localparam int unsigned ChW     = 8;
  localparam int unsigned BaseW   = 6;
  localparam int unsigned ValW    = 64;
  localparam int unsigned EndW    = 13;
  localparam int unsigned StatW   = 2;
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QIdxW   = 1;
  localparam int unsigned QCntW   = 2;

  localparam logic [BaseW-1:0] BaseReset = 6'd10;
  localparam logic [BaseW-1:0] NotDigit  = 6'd36;
  localparam logic [BaseW-1:0] MaxRadix  = 6'd36;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_NODIGITS = 2'd1;
  localparam logic [StatW-1:0] ST_RANGE    = 2'd2;
  localparam logic [StatW-1:0] ST_BADBASE  = 2'd3;

  localparam logic [ValW-1:0] LlongMax = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [ValW-1:0] LlongMin = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    PH_WS,
    PH_FIRST,
    PH_ZERO,
    PH_XSEEN,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic [ChW-1:0] ch;
    logic           start_req;
  } s2i_in_t;

  typedef struct packed {
    logic signed [ValW-1:0] value;
    logic [EndW-1:0]        end_index;
    logic [StatW-1:0]       status;
  } s2i_out_t;

  // Classified character as it travels from front to back.
  typedef struct packed {
    logic             start_req;
    logic [BaseW-1:0] digit;
    logic             is_space;
    logic             is_plus;
    logic             is_minus;
    logic             is_zero;
    logic             is_x;
  } s2i_tok_t;

endpackage

// ===== src/s2i_front.sv =====
module s2i_front
  import s2i_pkg::*;
(
  input  logic     in_valid_i,
  input  s2i_in_t  in_item_i,
  input  logic     q_full_i,
  output logic     push_o,
  output s2i_tok_t tok_o
);

  logic [ChW-1:0] c;

  assign c      = in_item_i.ch;
  assign push_o = in_valid_i && !q_full_i;

  always_comb begin
    tok_o           = '0;
    tok_o.start_req = in_item_i.start_req;
    tok_o.is_space  = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    tok_o.is_plus   = (c == 8'h2B);
    tok_o.is_minus  = (c == 8'h2D);
    tok_o.is_zero   = (c == 8'h30);
    tok_o.is_x      = (c == 8'h78) || (c == 8'h58);
    if (c >= 8'h30 && c <= 8'h39) begin
      tok_o.digit = BaseW'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      tok_o.digit = BaseW'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h5A) begin
      tok_o.digit = BaseW'(c - 8'h37);
    end else begin
      tok_o.digit = NotDigit;
    end
  end

endmodule

// ===== src/s2i_queue.sv =====
module s2i_queue
  import s2i_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  s2i_tok_t push_tok_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     valid_o,
  output s2i_tok_t head_o
);

  s2i_tok_t         mem_q [QDepth];
  logic [QIdxW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QIdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

// ===== src/s2i_back.sv =====
module s2i_back
  import s2i_pkg::*;
#(
  parameter int unsigned MaxLen = 4096,
  parameter int unsigned PosW   = 13
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [BaseW-1:0] base_select_i,
  input  logic             tok_valid_i,
  input  s2i_tok_t         tok_i,
  output logic             tok_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output s2i_out_t         out_item_o
);

  localparam int unsigned ExtW = (PosW > EndW) ? PosW : EndW;
  localparam int unsigned ProdW = ValW + BaseW;

  phase_e           phase_q, phase_d, ph;
  logic             neg_q, neg_d, neg_c;
  logic [ValW-1:0]  mag_q, mag_d, mag_c;
  logic [BaseW-1:0] rad_q, rad_d, rad_c;
  logic [PosW-1:0]  pos_q, pos_d, pos_c;
  logic [PosW-1:0]  lge_q, lge_d, lge_c;
  logic             ovf_q, ovf_d, ovf_c;

  logic             out_valid_q;
  s2i_out_t         out_q;

  s2i_tok_t         tk;
  logic             emit, take, fin, adv, start_num;
  logic [BaseW-1:0] r;
  logic [ProdW-1:0] prod;
  logic [ValW-1:0]  limit;
  logic [ExtW-1:0]  lge_ext;
  s2i_out_t         res;

  always_comb begin
    // a start request clears the parse state before the character is used
    ph    = tok_i.start_req ? PH_WS : phase_q;
    neg_c = tok_i.start_req ? 1'b0 : neg_q;
    mag_c = tok_i.start_req ? '0 : mag_q;
    rad_c = tok_i.start_req ? '0 : rad_q;
    pos_c = tok_i.start_req ? '0 : pos_q;
    lge_c = tok_i.start_req ? '0 : lge_q;
    ovf_c = tok_i.start_req ? 1'b0 : ovf_q;

    tk = tok_i;
    // past the length limit every character reads as NUL
    if (pos_c >= PosW'(MaxLen)) begin
      tk.digit    = NotDigit;
      tk.is_space = 1'b0;
      tk.is_plus  = 1'b0;
      tk.is_minus = 1'b0;
      tk.is_zero  = 1'b0;
      tk.is_x     = 1'b0;
    end

    phase_d   = ph;
    neg_d     = neg_c;
    mag_d     = mag_c;
    rad_d     = rad_c;
    pos_d     = pos_c;
    lge_d     = lge_c;
    ovf_d     = ovf_c;
    emit      = 1'b0;
    take      = 1'b0;
    fin       = 1'b0;
    adv       = 1'b0;
    start_num = 1'b0;
    r         = rad_c;
    res       = '0;

    if (ph != PH_DONE) begin
      if (ph == PH_WS && pos_c == '0) begin
        rad_d = base_select_i;
      end
      if (ph == PH_WS && pos_c == '0 &&
          (base_select_i == 6'd1 || base_select_i > MaxRadix)) begin
        phase_d    = PH_DONE;
        emit       = 1'b1;
        res.status = ST_BADBASE;
      end else begin
        priority case (ph)
          PH_WS: begin
            if (tk.is_space) begin
              adv = 1'b1;
            end else if (tk.is_plus || tk.is_minus) begin
              neg_d   = tk.is_minus;
              phase_d = PH_FIRST;
              adv     = 1'b1;
            end else begin
              start_num = 1'b1;
            end
          end
          PH_FIRST: start_num = 1'b1;
          PH_ZERO: begin
            if (tk.is_x) begin
              phase_d = PH_XSEEN;
              adv     = 1'b1;
            end else begin
              r     = (rad_d == '0) ? 6'd8 : rad_d;
              rad_d = r;
              if (tk.digit < r) take = 1'b1;
              else              fin  = 1'b1;
            end
          end
          PH_XSEEN: begin
            r = 6'd16;
            if (tk.digit < r) begin
              rad_d = r;
              take  = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end
          default: begin
            if (rad_d >= 6'd2 && tk.digit < rad_d) take = 1'b1;
            else                                   fin  = 1'b1;
          end
        endcase

        if (start_num) begin
          if (tk.is_zero && (rad_d == '0 || rad_d == 6'd16)) begin
            mag_d   = '0;
            lge_d   = pos_c + 1'b1;
            phase_d = PH_ZERO;
            adv     = 1'b1;
          end else begin
            r     = (rad_d == '0) ? 6'd10 : rad_d;
            rad_d = r;
            if (tk.digit < r) take = 1'b1;
            else              fin  = 1'b1;
          end
        end
      end
    end

    // multiply-add; overflow when the new value passes the signed limit
    limit = neg_c ? LlongMin : LlongMax;
    prod  = ProdW'(mag_c) * ProdW'(r) + ProdW'(tk.digit);
    if (take) begin
      if (!ovf_c) begin
        if (prod > ProdW'(limit)) ovf_d = 1'b1;
        else                      mag_d = prod[ValW-1:0];
      end
      lge_d   = pos_c + 1'b1;
      phase_d = PH_DIGITS;
      adv     = 1'b1;
    end

    lge_ext = ExtW'(lge_c);
    if (fin) begin
      phase_d = PH_DONE;
      emit    = 1'b1;
      if (lge_c == '0) begin
        res.status = ST_NODIGITS;
      end else if (ovf_c) begin
        res.value     = $signed(limit);
        res.end_index = lge_ext[EndW-1:0];
        res.status    = ST_RANGE;
      end else begin
        res.value     = $signed(neg_c ? (ValW'(0) - mag_c) : mag_c);
        res.end_index = lge_ext[EndW-1:0];
        res.status    = ST_OK;
      end
    end

    if (adv) pos_d = pos_c + 1'b1;
  end

  // items with no result keep flowing while the output register is held
  assign tok_pop_o   = tok_valid_i && (!emit || !out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WS;
      neg_q       <= 1'b0;
      mag_q       <= '0;
      rad_q       <= '0;
      pos_q       <= '0;
      lge_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tok_pop_o) begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        mag_q   <= mag_d;
        rad_q   <= rad_d;
        pos_q   <= pos_d;
        lge_q   <= lge_d;
        ovf_q   <= ovf_d;
      end
      if (tok_pop_o && emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_pop_o && emit) begin
      out_q <= res;
    end
  end

endmodule

// ===== src/string_to_int64_parser.sv =====
// String to signed 64-bit integer parser (strtoll semantics).
// Input channel: one character item per accepted cycle (in_valid_i high and
// in_stall_o low); start_req set on the first character of each string.
// Output channel: at most one result item (value, end_index, status) per string,
// taken when out_valid_o is high and out_stall_i is low.
// base_select is written via base_select_we_i/base_select_i, by the user only while
// idle (the block does not enforce it), and is sampled on each string's first character.
// Throughput: one character per cycle while in_stall_o is low; the bound is the
// back end's combinational multiply-add by the radix with its overflow compare.
// The character that ends the number is held in the 2-entry queue, and the back
// end registers its result in the output register when it pops that character.
// Reset: base_select returns to 10, parse state clears, the queue empties.
// Output stall: the result register holds; characters that give no result
// keep being consumed, and once the item that causes a second result waits
// at the queue head, one more item fills the queue and in_stall_o rises.
`include "string_to_int64_parser_macros.svh"

module string_to_int64_parser
  import s2i_pkg::*;
#(
  parameter int unsigned MAX_LEN = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  s2i_in_t          in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output s2i_out_t         out_item_o,
  input  logic             base_select_we_i,
  input  logic [BaseW-1:0] base_select_i
);

  localparam int unsigned PosW = $clog2(MAX_LEN + 1);

  logic [BaseW-1:0] base_select_q;
  logic             push, pop, q_full, q_valid;
  s2i_tok_t         push_tok, head_tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_select_q <= BaseReset;
    end else if (base_select_we_i) begin
      base_select_q <= base_select_i;
    end
  end

  assign in_stall_o = q_full;

  s2i_front u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .tok_o      (push_tok)
  );

  s2i_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_tok_i (push_tok),
    .pop_i      (pop),
    .full_o     (q_full),
    .valid_o    (q_valid),
    .head_o     (head_tok)
  );

  s2i_back #(
    .MaxLen (MAX_LEN),
    .PosW   (PosW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .base_select_i (base_select_q),
    .tok_valid_i   (q_valid),
    .tok_i         (head_tok),
    .tok_pop_o     (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

  `S2I_ASSERT_NOW(a_badbase_zero, clk_i, rst_ni,
    out_valid_o && out_item_o.status == ST_BADBASE,
    out_item_o.value == 64'sd0 && out_item_o.end_index == '0)
  `S2I_ASSERT_NOW(a_nodigits_zero, clk_i, rst_ni,
    out_valid_o && out_item_o.status == ST_NODIGITS,
    out_item_o.value == 64'sd0 && out_item_o.end_index == '0)
  `S2I_ASSERT_NOW(a_range_saturates, clk_i, rst_ni,
    out_valid_o && out_item_o.status == ST_RANGE,
    out_item_o.value == $signed(LlongMax) || out_item_o.value == $signed(LlongMin))
  `S2I_ASSERT_NEXT(a_full_stalls, clk_i, rst_ni,
    q_full && !pop,
    in_stall_o)

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import s2i_pkg::*;

  localparam int unsigned MaxLen     = 4096;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainWait  = 8;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  s2i_in_t          in_item_i;
  logic             out_valid_o;
  logic             out_stall_i;
  s2i_out_t         out_item_o;
  logic             base_select_we_i;
  logic [BaseW-1:0] base_select_i;

  string_to_int64_parser #(
    .MAX_LEN(MaxLen)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_item_i       (in_item_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_item_o      (out_item_o),
    .base_select_we_i(base_select_we_i),
    .base_select_i   (base_select_i)
  );

  // Parser state as the checker sees it
  logic [BaseW-1:0] base_reg;
  phase_e           pr_phase;
  logic             pr_neg;
  logic [ValW-1:0]  pr_mag;
  logic [BaseW-1:0] pr_radix;
  int unsigned      pr_pos;
  int unsigned      pr_end;
  logic             pr_ovf;

  s2i_out_t expected_parses[$];
  int       fail_count;
  int       snd_idle_pct;
  int       rcv_stall_pct;
  logic     out_take;
  s2i_out_t out_got;
  s2i_out_t want_res;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  function automatic logic [BaseW-1:0] char_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return BaseW'(c - "0");
    if (c >= "a" && c <= "z") return BaseW'(c - "a" + 8'd10);
    if (c >= "A" && c <= "Z") return BaseW'(c - "A" + 8'd10);
    return NotDigit;
  endfunction

  function automatic bit is_ws(input logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void clear_parse();
    pr_phase = PH_WS;
    pr_neg   = 1'b0;
    pr_mag   = '0;
    pr_radix = '0;
    pr_pos   = 0;
    pr_end   = 0;
    pr_ovf   = 1'b0;
  endfunction

  function automatic void add_digit(input logic [BaseW-1:0] d, input logic [BaseW-1:0] r);
    logic [ValW-1:0] lim;
    lim = pr_neg ? LlongMin : LlongMax;
    // once saturated, digits are still consumed but no longer accumulated
    if (!pr_ovf) begin
      if (pr_mag > (lim - d) / r) pr_ovf = 1'b1;
      else pr_mag = pr_mag * r + d;
    end
    pr_end   = pr_pos + 1;
    pr_phase = PH_DIGITS;
  endfunction

  function automatic s2i_out_t finish_parse();
    s2i_out_t r;
    r = '0;
    pr_phase = PH_DONE;
    if (pr_end == 0) begin
      r.status = ST_NODIGITS;
    end else begin
      r.end_index = EndW'(pr_end);
      if (pr_ovf) begin
        r.value  = pr_neg ? LlongMin : LlongMax;
        r.status = ST_RANGE;
      end else begin
        r.value  = pr_neg ? -pr_mag : pr_mag;
        r.status = ST_OK;
      end
    end
    return r;
  endfunction

  // Returns 1 when this item ends the parse; r then holds the result.
  function automatic bit parse_char(input s2i_in_t it, output s2i_out_t r);
    logic [7:0]       c;
    logic [BaseW-1:0] d;
    c = it.ch;
    r = '0;
    if (it.start_req) clear_parse();
    if (pr_phase == PH_DONE) return 0;
    if (pr_phase == PH_WS && pr_pos == 0) begin
      pr_radix = base_reg;
      if (pr_radix == 1 || pr_radix > MaxRadix) begin
        pr_phase = PH_DONE;
        r.status = ST_BADBASE;
        return 1;
      end
    end
    if (pr_pos >= MaxLen) c = 8'h00;
    d = char_digit(c);
    if (pr_phase == PH_WS && is_ws(c)) begin
      pr_pos++;
      return 0;
    end
    if (pr_phase == PH_WS && (c == "+" || c == "-")) begin
      pr_neg   = (c == "-");
      pr_phase = PH_FIRST;
      pr_pos++;
      return 0;
    end
    case (pr_phase)
      PH_WS, PH_FIRST: begin
        if (c == "0" && (pr_radix == 0 || pr_radix == 16)) begin
          pr_mag   = '0;
          pr_end   = pr_pos + 1;
          pr_phase = PH_ZERO;
        end else begin
          if (pr_radix == 0) pr_radix = 6'd10;
          if (d < pr_radix) add_digit(d, pr_radix);
          else begin
            r = finish_parse();
            return 1;
          end
        end
      end
      PH_ZERO: begin
        if (c == "x" || c == "X") begin
          pr_phase = PH_XSEEN;
        end else begin
          if (pr_radix == 0) pr_radix = 6'd8;
          if (d < pr_radix) add_digit(d, pr_radix);
          else begin
            r = finish_parse();
            return 1;
          end
        end
      end
      PH_XSEEN: begin
        if (d < 16) begin
          pr_radix = 6'd16;
          add_digit(d, 6'd16);
        end else begin
          r = finish_parse();
          return 1;
        end
      end
      default: begin
        if (pr_radix >= 2 && d < pr_radix) add_digit(d, pr_radix);
        else begin
          r = finish_parse();
          return 1;
        end
      end
    endcase
    pr_pos++;
    return 0;
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned d, input bit upper);
    if (d < 10) return 8'(d) + "0";
    return 8'(d - 10) + (upper ? "A" : "a");
  endfunction

  // Receiver side
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rcv_stall_pct);
  end

  always @(negedge clk_i) begin
    out_take = out_valid_o && !out_stall_i;
    out_got  = out_item_o;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_take) begin
      if (expected_parses.size() == 0) begin
        $error("result item with no parse pending");
        fail_count++;
      end else begin
        want_res = expected_parses.pop_front();
        if (out_got.value !== want_res.value) begin
          $error("value: expected %0d, got %0d", want_res.value, out_got.value);
          fail_count++;
        end
        if (out_got.end_index !== want_res.end_index) begin
          $error("end_index: expected %0d, got %0d", want_res.end_index, out_got.end_index);
          fail_count++;
        end
        if (out_got.status !== want_res.status) begin
          $error("status: expected %0d, got %0d", want_res.status, out_got.status);
          fail_count++;
        end
      end
    end
  end

  // Called at a rising edge; returns at the edge where the item was taken.
  task automatic send_char(input logic [7:0] c, input logic sr);
    s2i_in_t  it;
    s2i_out_t res;
    bit       took;
    it.ch        = c;
    it.start_req = sr;
    // each idle cycle is drawn on its own
    while (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    if (parse_char(it, res)) expected_parses.push_back(res);
  endtask

  task automatic send_str(input string s, input bit with_nul);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0);
    if (with_nul) send_char(8'h00, s.len() == 0);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_parses.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic write_base(input logic [BaseW-1:0] b);
    drain();
    base_select_we_i <= 1'b1;
    base_select_i    <= b;
    @(posedge clk_i);
    base_select_we_i <= 1'b0;
    base_reg = b;
  endtask

  task automatic test_decimal();
    write_base(6'd10);
    send_str(" \t-9223372036854775808", 1'b1);
    send_str("9223372036854775807 ", 1'b0);
    send_str("+9223372036854775808", 1'b1);
    send_str("", 1'b1);
    send_str("-z", 1'b0);
    // trailing characters after the result are dropped
    send_str("5;9", 1'b0);
  endtask

  task automatic test_restart();
    send_str("12", 1'b0);
    send_str("7", 1'b1);
  endtask

  task automatic test_auto_radix();
    write_base(6'd0);
    send_str("0x1fG", 1'b0);
    send_str("0xg", 1'b0);
    send_str("0178", 1'b0);
    send_str("95a", 1'b0);
    send_str("0", 1'b1);
  endtask

  task automatic test_radix_edges();
    write_base(6'd16);
    send_str("0Xff", 1'b1);
    send_str("-0x8000000000000000", 1'b1);
    write_base(6'd36);
    send_str("zZ", 1'b1);
    write_base(6'd2);
    send_str("102", 1'b0);
  endtask

  task automatic test_bad_base();
    write_base(6'd1);
    send_str("42", 1'b1);
    write_base(6'd63);
    send_str("7", 1'b1);
  endtask

  function automatic logic [BaseW-1:0] pick_base();
    case ($urandom_range(9))
      0: return 6'd0;
      1: return 6'd2;
      2: return 6'd36;
      3: return 6'd16;
      4: return 6'd8;
      5: begin
        if ($urandom_range(3) != 0) return 6'd10;
        return $urandom_range(1) ? 6'd1 : BaseW'($urandom_range(63, 37));
      end
      default: return BaseW'($urandom_range(36, 2));
    endcase
  endfunction

  task automatic test_random_strings(input int n_items, input int snd_pct, input int rcv_pct);
    logic [7:0]  txt[$];
    int          sent;
    int unsigned gen_radix;
    int unsigned ndig;
    logic [7:0]  term;
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(7) == 0) write_base(pick_base());
      if ($urandom_range(9) == 0) begin
        // noise: raw bytes, start marks anywhere
        repeat ($urandom_range(1, 8)) begin
          send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
          sent++;
        end
      end else begin
        txt = {};
        repeat ($urandom_range(2)) begin
          txt.push_back($urandom_range(5) == 5 ? 8'h20 : 8'(8'h09 + $urandom_range(4)));
        end
        case ($urandom_range(3))
          0: txt.push_back("-");
          1: txt.push_back("+");
          default: ;
        endcase
        if (base_reg >= 2 && base_reg <= MaxRadix) gen_radix = base_reg;
        else if (base_reg == 0) begin
          case ($urandom_range(2))
            0: gen_radix = 8;
            1: gen_radix = 10;
            default: gen_radix = 16;
          endcase
        end else gen_radix = 10;
        if (gen_radix == 16 && (base_reg == 0 || $urandom_range(4) != 0)) begin
          txt.push_back("0");
          txt.push_back($urandom_range(1) ? "x" : "X");
        end else if (gen_radix == 8 && base_reg == 0) begin
          txt.push_back("0");
        end
        ndig = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(12);
        repeat (ndig) begin
          txt.push_back(digit_char($urandom_range(gen_radix - 1), 1'($urandom_range(1))));
        end
        case ($urandom_range(4))
          0: term = 8'h00;
          1: term = " ";
          2: term = (gen_radix < 36) ?
                    digit_char($urandom_range(35, gen_radix), 1'($urandom_range(1))) : "!";
          default: term = 8'($urandom_range(255));
        endcase
        // now and then leave the string open so the next start cuts it off
        if ($urandom_range(11) != 0) txt.push_back(term);
        for (int i = 0; i < txt.size(); i++) send_char(txt[i], i == 0);
        if (txt.size() == 0) send_char(8'h00, 1'b1);
        sent += (txt.size() == 0) ? 1 : txt.size();
      end
    end
  endtask

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    in_item_i        = '0;
    base_select_we_i = 1'b0;
    base_select_i    = '0;
    fail_count       = 0;
    snd_idle_pct     = 12;
    rcv_stall_pct    = 62;
    base_reg         = BaseReset;
    clear_parse();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_decimal();
    test_restart();
    test_auto_radix();
    test_radix_edges();
    test_bad_base();
    test_random_strings(540, 12, 62);
    test_random_strings(540, 62, 12);
    test_random_strings(540, 0, 0);

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
